[rtl/gcdr_pkg.sv]
// Shared types, codes and defaults for the grid cost distance relaxation block.
package gcdr_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_ROWS  = 128;
    localparam int DEF_MAX_COLS  = 128;
    localparam int DEF_COST_BITS = 16;
    localparam int DEF_DIST_BITS = 32;

    // Fixed field widths of the item formats
    localparam int ROW_W    = 7;
    localparam int COL_W    = 7;
    localparam int CCOST_W  = 16;
    localparam int MARGIN_W = 16;
    localparam int BOUND_W  = 8;
    localparam int OUT_W    = 32;

    // Register reset values
    localparam logic [MARGIN_W-1:0] RST_MARGIN = 16'd1;
    localparam logic [BOUND_W-1:0]  RST_ROWS   = 8'd128;
    localparam logic [BOUND_W-1:0]  RST_COLS   = 8'd128;

    // Register indexes (byte address is four times the index)
    localparam logic [2:0] REG_MARGIN    = 3'd0;
    localparam logic [2:0] REG_ROWS      = 3'd1;
    localparam logic [2:0] REG_COLS      = 3'd2;
    localparam logic [2:0] REG_START_ROW = 3'd3;
    localparam logic [2:0] REG_START_COL = 3'd4;

    // Neighbour slot codes within one cell visit
    localparam logic [2:0] SLOT_OWN   = 3'd0;
    localparam logic [2:0] SLOT_DOWN  = 3'd1;
    localparam logic [2:0] SLOT_UP    = 3'd2;
    localparam logic [2:0] SLOT_RIGHT = 3'd3;
    localparam logic [2:0] SLOT_LEFT  = 3'd4;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        WSEL_INF  = 2'd0,
        WSEL_ZERO = 2'd1,
        WSEL_CAND = 2'd2
    } wsel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic  cost_we;
        logic  dist_we;
        wsel_t wsel;
        logic  clr_best;
        logic  cap_own;
        logic  cap_nb;
        logic  nb_use;
        logic  calc;
        logic  decide;
        logic  upd;
        logic  clr_total;
        logic  clr_sweep;
        logic  cap_read;
        logic  rd_inside;
        logic  out_load;
        logic  res_read;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sweep_changed;
        logic out_free;
    } sts_t;

endpackage

[rtl/gcdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gcdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gcdr_dp.sv]
// Datapath: cost and distance stores, relaxation arithmetic, counters and result register.
module gcdr_dp #(
    parameter int MAX_ROWS  = gcdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gcdr_pkg::DEF_MAX_COLS,
    parameter int COST_BITS = gcdr_pkg::DEF_COST_BITS,
    parameter int DIST_BITS = gcdr_pkg::DEF_DIST_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  gcdr_pkg::cmd_t                         cmd,
    output gcdr_pkg::sts_t                         sts,
    input  logic [COST_BITS-1:0]                   cost_in,
    input  logic [gcdr_pkg::MARGIN_W-1:0]          margin,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   cost_waddr,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   dist_waddr,
    input  logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]   rd_addr,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic [gcdr_pkg::OUT_W-1:0]             m_distance,
    output logic                                   m_unreached,
    output logic [gcdr_pkg::OUT_W-1:0]             m_writes
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int SW     = ((DIST_BITS > COST_BITS) ? DIST_BITS : COST_BITS) + 1;
    localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};
    localparam logic [gcdr_pkg::OUT_W-1:0] SAT = {gcdr_pkg::OUT_W{1'b1}};

    logic [COST_BITS-1:0] cost_rdata;
    logic [DIST_BITS-1:0] dist_rdata;
    logic                 dist_we;
    logic [DIST_BITS-1:0] dist_wdata;

    logic [DIST_BITS-1:0] best_reg, own_dist_reg, cand_reg, rd_val_reg;
    logic [COST_BITS-1:0] own_cost_reg;
    logic                 ok_reg, sweep_reg;
    logic [gcdr_pkg::OUT_W-1:0] total_reg;
    logic                 valid_reg, unr_reg;
    logic [gcdr_pkg::OUT_W-1:0] dist_out_reg, writes_out_reg;

    logic [DIST_BITS-1:0] via, cand_next, cand_marg;

    // Saturating add: any sum at or above infinity becomes infinity
    function automatic logic [DIST_BITS-1:0] sat_add(input logic [SW-1:0] a,
                                                      input logic [SW-1:0] b);
        logic [SW-1:0] s;
        s = a + b;
        return (s >= SW'(INF)) ? INF : DIST_BITS'(s);
    endfunction

    gcdr_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost_ram (
        .aclk  (aclk),
        .we    (cmd.cost_we),
        .waddr (cost_waddr),
        .wdata (cost_in),
        .raddr (rd_addr),
        .rdata (cost_rdata)
    );

    gcdr_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist_ram (
        .aclk  (aclk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (rd_addr),
        .rdata (dist_rdata)
    );

    // Select the distance write source
    always_comb begin
        dist_we = cmd.dist_we | (cmd.upd & ok_reg);
        case (cmd.wsel)
            gcdr_pkg::WSEL_ZERO: dist_wdata = '0;
            gcdr_pkg::WSEL_CAND: dist_wdata = cand_reg;
            default:             dist_wdata = INF;
        endcase
    end

    // Relaxation arithmetic
    assign via       = sat_add(SW'(dist_rdata), SW'(cost_rdata));
    assign cand_next = sat_add(SW'(best_reg), SW'(own_cost_reg));
    assign cand_marg = sat_add(SW'(cand_reg), SW'(margin));

    // Collect the neighbour minimum and decide the write
    always_ff @(posedge aclk) begin
        if (cmd.clr_best) begin
            best_reg <= INF;
        end else if (cmd.cap_nb && cmd.nb_use && (via < best_reg)) begin
            best_reg <= via;
        end
        if (cmd.cap_own) begin
            own_dist_reg <= dist_rdata;
            own_cost_reg <= cost_rdata;
        end
        if (cmd.calc) begin
            cand_reg <= cand_next;
        end
        if (cmd.decide) begin
            ok_reg <= (cand_reg != INF) && (cand_marg < own_dist_reg);
        end
        if (cmd.cap_read) begin
            rd_val_reg <= cmd.rd_inside ? dist_rdata : INF;
        end
    end

    // Count writes per solve and flag writes per sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sweep_reg <= 1'b0;
        end else begin
            if (cmd.clr_total) begin
                total_reg <= '0;
            end else if (cmd.upd && ok_reg && (total_reg != SAT)) begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.clr_sweep) begin
                sweep_reg <= 1'b0;
            end else if (cmd.upd && ok_reg) begin
                sweep_reg <= 1'b1;
            end
        end
    end

    // Hold the result item until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.res_read) begin
                dist_out_reg   <= gcdr_pkg::OUT_W'(rd_val_reg);
                unr_reg        <= (rd_val_reg == INF);
                writes_out_reg <= '0;
            end else begin
                dist_out_reg   <= '0;
                unr_reg        <= 1'b0;
                writes_out_reg <= total_reg;
            end
        end
    end

    assign sts.sweep_changed = sweep_reg;
    assign sts.out_free      = !valid_reg || m_ready;
    assign m_valid           = valid_reg;
    assign m_distance        = dist_out_reg;
    assign m_unreached       = unr_reg;
    assign m_writes          = writes_out_reg;

endmodule

[rtl/gcdr_ctrl.sv]
// Controller: item handshake, store clearing, sweep sequencing and result hand-off.
module gcdr_ctrl #(
    parameter int MAX_ROWS = gcdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gcdr_pkg::DEF_MAX_COLS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           in_kind,
    input  logic [gcdr_pkg::ROW_W-1:0]           in_row,
    input  logic [gcdr_pkg::COL_W-1:0]           in_col,
    input  logic [gcdr_pkg::BOUND_W-1:0]         rows_in_use,
    input  logic [gcdr_pkg::BOUND_W-1:0]         cols_in_use,
    input  logic [gcdr_pkg::ROW_W-1:0]           start_row,
    input  logic [gcdr_pkg::COL_W-1:0]           start_col,
    output gcdr_pkg::cmd_t                       cmd,
    input  gcdr_pkg::sts_t                       sts,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] cost_waddr,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] dist_waddr,
    output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] rd_addr
);

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int NRW    = $clog2(MAX_ROWS + 1);
    localparam int NCW    = $clog2(MAX_COLS + 1);
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_COLS);
    localparam logic [ADDR_W-1:0] LAST   = ADDR_W'(CELLS - 1);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_CLEAR     = 12'b0000_0000_0010,
        ST_START     = 12'b0000_0000_0100,
        ST_ISSUE     = 12'b0000_0000_1000,
        ST_DRAIN     = 12'b0000_0001_0000,
        ST_CALC      = 12'b0000_0010_0000,
        ST_DECIDE    = 12'b0000_0100_0000,
        ST_WRITE     = 12'b0000_1000_0000,
        ST_SWEEP_END = 12'b0001_0000_0000,
        ST_RD_ISSUE  = 12'b0010_0000_0000,
        ST_RD_CAP    = 12'b0100_0000_0000,
        ST_RESULT    = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [RW-1:0]     r_reg;
    logic [CW-1:0]     c_reg;
    logic [2:0]        slot_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] in_idx_reg;
    logic              inside_reg, read_reg;
    logic              cap_own_reg, cap_nb_reg, nb_use_reg;

    logic [NRW-1:0]    nr;
    logic [NCW-1:0]    nc;
    logic [ADDR_W-1:0] cell_idx, in_idx, start_idx;
    logic              in_inside, start_ok, nb_use, last_col, last_cell;

    // Active bounds: zero acts as one, large values clip to the store size
    always_comb begin
        if (rows_in_use == '0) begin
            nr = NRW'(1);
        end else if (32'(rows_in_use) > MAX_ROWS) begin
            nr = NRW'(MAX_ROWS);
        end else begin
            nr = NRW'(rows_in_use);
        end
        if (cols_in_use == '0) begin
            nc = NCW'(1);
        end else if (32'(cols_in_use) > MAX_COLS) begin
            nc = NCW'(MAX_COLS);
        end else begin
            nc = NCW'(cols_in_use);
        end
    end

    // Cell indexes
    assign cell_idx  = ADDR_W'(r_reg) * STRIDE + ADDR_W'(c_reg);
    assign in_idx    = ADDR_W'(in_row) * STRIDE + ADDR_W'(in_col);
    assign start_idx = ADDR_W'(start_row) * STRIDE + ADDR_W'(start_col);
    assign in_inside = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
    assign start_ok  = (32'(start_row) < 32'(nr)) && (32'(start_col) < 32'(nc));
    assign last_col  = (32'(c_reg) + 1 == 32'(nc));
    assign last_cell = last_col && (32'(r_reg) + 1 == 32'(nr));

    // Neighbour present for the current slot
    always_comb begin
        case (slot_reg)
            gcdr_pkg::SLOT_DOWN:  nb_use = (32'(r_reg) + 1 < 32'(nr));
            gcdr_pkg::SLOT_UP:    nb_use = (r_reg != '0);
            gcdr_pkg::SLOT_RIGHT: nb_use = (32'(c_reg) + 1 < 32'(nc));
            gcdr_pkg::SLOT_LEFT:  nb_use = (c_reg != '0);
            default:              nb_use = 1'b0;
        endcase
    end

    // Next state, commands and addresses
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.wsel    = gcdr_pkg::WSEL_INF;
        cmd.cap_own = cap_own_reg;
        cmd.cap_nb  = cap_nb_reg;
        cmd.nb_use  = nb_use_reg;
        s_ready     = 1'b0;
        cost_waddr  = in_idx;
        dist_waddr  = cell_idx;
        rd_addr     = cell_idx;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (in_kind)
                        gcdr_pkg::KIND_LOAD:  cmd.cost_we = in_inside;
                        gcdr_pkg::KIND_SOLVE: begin
                            cmd.clr_total = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        gcdr_pkg::KIND_READ:  state_next = ST_RD_ISSUE;
                        default:              state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.dist_we = 1'b1;
                dist_waddr  = clr_reg;
                if (clr_reg == LAST) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.dist_we   = start_ok;
                cmd.wsel      = gcdr_pkg::WSEL_ZERO;
                cmd.clr_sweep = 1'b1;
                dist_waddr    = start_idx;
                state_next    = ST_ISSUE;
            end
            ST_ISSUE: begin
                case (slot_reg)
                    gcdr_pkg::SLOT_DOWN:  rd_addr = cell_idx + STRIDE;
                    gcdr_pkg::SLOT_UP:    rd_addr = cell_idx - STRIDE;
                    gcdr_pkg::SLOT_RIGHT: rd_addr = cell_idx + 1'b1;
                    gcdr_pkg::SLOT_LEFT:  rd_addr = cell_idx - 1'b1;
                    default:              rd_addr = cell_idx;
                endcase
                cmd.clr_best = (slot_reg == gcdr_pkg::SLOT_OWN);
                if (slot_reg == gcdr_pkg::SLOT_LEFT) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_CALC;
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.upd    = 1'b1;
                cmd.wsel   = gcdr_pkg::WSEL_CAND;
                state_next = last_cell ? ST_SWEEP_END : ST_ISSUE;
            end
            ST_SWEEP_END: begin
                if (sts.sweep_changed) begin
                    cmd.clr_sweep = 1'b1;
                    state_next    = ST_ISSUE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_RD_ISSUE: begin
                rd_addr    = in_idx_reg;
                state_next = ST_RD_CAP;
            end
            ST_RD_CAP: begin
                cmd.cap_read  = 1'b1;
                cmd.rd_inside = inside_reg;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                cmd.res_read = read_reg;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_own_reg <= 1'b0;
            cap_nb_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_own_reg <= (state_reg == ST_ISSUE) && (slot_reg == gcdr_pkg::SLOT_OWN);
            cap_nb_reg  <= (state_reg == ST_ISSUE) && (slot_reg != gcdr_pkg::SLOT_OWN);
        end
    end

    // Counters and captured item fields
    always_ff @(posedge aclk) begin
        nb_use_reg <= nb_use;
        if (state_reg == ST_IDLE && s_valid) begin
            in_idx_reg <= in_idx;
            inside_reg <= in_inside;
            read_reg   <= (in_kind == gcdr_pkg::KIND_READ);
            clr_reg    <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (state_reg == ST_ISSUE) begin
            slot_reg <= (slot_reg == gcdr_pkg::SLOT_LEFT) ? gcdr_pkg::SLOT_OWN
                                                          : slot_reg + 1'b1;
        end else if (state_reg == ST_START) begin
            slot_reg <= gcdr_pkg::SLOT_OWN;
        end
        if (state_reg == ST_START || state_reg == ST_SWEEP_END) begin
            r_reg <= '0;
            c_reg <= '0;
        end else if (state_reg == ST_WRITE && !last_cell) begin
            if (last_col) begin
                c_reg <= '0;
                r_reg <= r_reg + 1'b1;
            end else begin
                c_reg <= c_reg + 1'b1;
            end
        end
    end

    // Items are taken only when the block is idle
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("input taken outside idle");

    // Cost store is written only by an accepted load item
    a_cost_we: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cost_we |-> (s_valid && state_reg == ST_IDLE))
        else $error("cost write without load item");

    // A result loaded into the output register returns the block to idle
    a_result_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == ST_IDLE))
        else $error("result hand-off did not finish the item");

    // A cell visit reads all five slots before deciding
    a_visit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> ($past(state_reg) == ST_ISSUE && cap_nb_reg))
        else $error("cell visit cut short");

endmodule

[rtl/grid_cost_distance_relaxation.sv]
// Top level: stream ports, configuration registers, controller and datapath.
//
//  channel | group             | carries
//  --------+-------------------+------------------------------------------
//  input   | s_tvalid/s_tready | load, solve or read item
//  result  | m_tvalid/m_tready | distance or solve write count
//  config  | psel/penable/...  | margin, active rows and columns, start cell
//
//  A load item writes the cost store as it is taken. A read item fetches one
//  distance into the result register. A solve item clears the distance store
//  (MAX_ROWS*MAX_COLS cells), sets the start cell to zero if it is inside the
//  active area, then sweeps the active cells, visiting each cell's own and
//  four neighbour slots, until a sweep writes nothing, and hands over the
//  result. Reset is synchronous and active low; a clearing pass runs at each
//  solve. A stalled result holds the block before its next item.
module grid_cost_distance_relaxation #(
    parameter int MAX_ROWS  = gcdr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = gcdr_pkg::DEF_MAX_COLS,
    parameter int COST_BITS = gcdr_pkg::DEF_COST_BITS,
    parameter int DIST_BITS = gcdr_pkg::DEF_DIST_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_row[6:0], cell_col[13:7], cell_cost[29:14]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // distance[31:0], write_count[63:32]
    output logic [0:0]  m_tuser,   // unreached[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

    logic [gcdr_pkg::MARGIN_W-1:0] margin_reg;
    logic [gcdr_pkg::BOUND_W-1:0]  rows_reg, cols_reg;
    logic [gcdr_pkg::ROW_W-1:0]    srow_reg;
    logic [gcdr_pkg::COL_W-1:0]    scol_reg;
    logic [2:0]                    reg_idx;
    logic                          cfg_wr;

    gcdr_pkg::cmd_t    cmd;
    gcdr_pkg::sts_t    sts;
    logic [ADDR_W-1:0] cost_waddr, dist_waddr, rd_addr;
    logic [gcdr_pkg::OUT_W-1:0] out_dist, out_writes;
    logic                       out_unr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= gcdr_pkg::RST_MARGIN;
            rows_reg   <= gcdr_pkg::RST_ROWS;
            cols_reg   <= gcdr_pkg::RST_COLS;
            srow_reg   <= '0;
            scol_reg   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                gcdr_pkg::REG_MARGIN:    margin_reg <= pwdata[gcdr_pkg::MARGIN_W-1:0];
                gcdr_pkg::REG_ROWS:      rows_reg   <= pwdata[gcdr_pkg::BOUND_W-1:0];
                gcdr_pkg::REG_COLS:      cols_reg   <= pwdata[gcdr_pkg::BOUND_W-1:0];
                gcdr_pkg::REG_START_ROW: srow_reg   <= pwdata[gcdr_pkg::ROW_W-1:0];
                gcdr_pkg::REG_START_COL: scol_reg   <= pwdata[gcdr_pkg::COL_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            gcdr_pkg::REG_MARGIN:    prdata = 32'(margin_reg);
            gcdr_pkg::REG_ROWS:      prdata = 32'(rows_reg);
            gcdr_pkg::REG_COLS:      prdata = 32'(cols_reg);
            gcdr_pkg::REG_START_ROW: prdata = 32'(srow_reg);
            gcdr_pkg::REG_START_COL: prdata = 32'(scol_reg);
            default:                 prdata = '0;
        endcase
    end

    gcdr_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .in_kind     (s_tuser),
        .in_row      (s_tdata[6:0]),
        .in_col      (s_tdata[13:7]),
        .rows_in_use (rows_reg),
        .cols_in_use (cols_reg),
        .start_row   (srow_reg),
        .start_col   (scol_reg),
        .cmd         (cmd),
        .sts         (sts),
        .cost_waddr  (cost_waddr),
        .dist_waddr  (dist_waddr),
        .rd_addr     (rd_addr)
    );

    gcdr_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .COST_BITS (COST_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cost_in     (COST_BITS'(s_tdata[29:14])),
        .margin      (margin_reg),
        .cost_waddr  (cost_waddr),
        .dist_waddr  (dist_waddr),
        .rd_addr     (rd_addr),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_distance  (out_dist),
        .m_unreached (out_unr),
        .m_writes    (out_writes)
    );

    assign m_tdata = {out_writes, out_dist};
    assign m_tuser = out_unr;

endmodule
